/* rtl/core/htfl_pkg.sv */
// ----------------------------------------------------------------------------
// htfl_pkg
// Shared widths, opcodes, status codes and the command word of the handle
// table free list.
// ----------------------------------------------------------------------------
package htfl_pkg;

	localparam int MAX_HANDLES_DEF = 1024;
	localparam int NUM_TYPES       = 8;

	localparam int OPCODE_W = 2;
	localparam int HID_W    = 16;
	localparam int TYPE_W   = 3;
	localparam int STATUS_W = 2;

	localparam logic [OPCODE_W-1:0] OP_ADD     = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_FREE    = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_LOOKUP  = 2'd2;
	localparam logic [OPCODE_W-1:0] OP_DESTROY = 2'd3;

	localparam logic [TYPE_W-1:0] TYPE_INVALID  = 3'd0;
	localparam logic [TYPE_W-1:0] TYPE_RESERVED = 3'd1;
	localparam logic [TYPE_W-1:0] TYPE_ANY      = 3'd0;

	localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STS_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 2'd2;
	localparam logic [STATUS_W-1:0] STS_BAD_TYPE  = 2'd3;

	// classified request, minus the handle index whose width follows the table size
	typedef struct packed {
		logic [OPCODE_W-1:0] op;
		logic                hid_ok;
		logic                type_ok;
		logic [TYPE_W-1:0]   obj_type;
		logic [TYPE_W-1:0]   want_type;
	} cmd_t;

endpackage

/* rtl/core/htfl_in_if.sv */
// ----------------------------------------------------------------------------
// htfl_in_if
// Request channel: opcode, handle and types, with valid/ready.
// ----------------------------------------------------------------------------
interface htfl_in_if;
	import htfl_pkg::*;

	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [HID_W-1:0]    handle_id;
	logic [TYPE_W-1:0]   obj_type;
	logic [TYPE_W-1:0]   want_type;

	modport source (output valid, output opcode, output handle_id, output obj_type,
		output want_type, input ready);
	modport sink (input valid, input opcode, input handle_id, input obj_type,
		input want_type, output ready);

endinterface

/* rtl/core/htfl_out_if.sv */
// ----------------------------------------------------------------------------
// htfl_out_if
// Response channel: status, handle and type, with valid/ready.
// ----------------------------------------------------------------------------
interface htfl_out_if #(
	parameter int HANDLE_W = $clog2(htfl_pkg::MAX_HANDLES_DEF)
);
	import htfl_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [HANDLE_W-1:0] result_handle;
	logic [TYPE_W-1:0]   result_type;

	modport source (output valid, output status, output result_handle,
		output result_type, input ready);
	modport sink (input valid, input status, input result_handle,
		input result_type, output ready);

endinterface

/* rtl/core/htfl_ram.sv */
// ----------------------------------------------------------------------------
// htfl_ram
// Generic RAM, one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module htfl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/htfl_front.sv */
// ----------------------------------------------------------------------------
// htfl_front
// Takes request words, checks handle range and add type, and queues the
// classified command for the back end in a two-entry queue.
// ----------------------------------------------------------------------------
module htfl_front #(
	parameter int MAX_HANDLES = htfl_pkg::MAX_HANDLES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	htfl_in_if.sink                        req,
	output htfl_pkg::cmd_t                 cmd,
	output logic [$clog2(MAX_HANDLES)-1:0] cmd_idx,
	output logic                           cmd_valid,
	input  logic                           cmd_ready
);
	import htfl_pkg::*;

	localparam int HW = $clog2(MAX_HANDLES);

	cmd_t          fifo_cmd_q [2];
	logic [HW-1:0] fifo_idx_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;

	cmd_t          cls;
	logic          push;
	logic          pop;

	always_comb begin
		cls.op        = req.opcode;
		cls.hid_ok    = (req.handle_id != '0) &&
			({1'b0, req.handle_id} < (HID_W+1)'(MAX_HANDLES));
		cls.type_ok   = (req.obj_type != TYPE_INVALID) &&
			({2'b00, req.obj_type} < 5'(NUM_TYPES));
		cls.obj_type  = req.obj_type;
		cls.want_type = req.want_type;
	end

	assign req.ready = (cnt_q != 2'd2);
	assign push      = req.valid && req.ready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_cmd_q[wr_ptr_q] <= cls;
			fifo_idx_q[wr_ptr_q] <= req.handle_id[HW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assign cmd     = fifo_cmd_q[rd_ptr_q];
	assign cmd_idx = fifo_idx_q[rd_ptr_q];

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("queue count out of range");
	a_full_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2) |-> !req.ready)
		else $error("request accepted into a full queue");
	a_pop_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (cnt_q != 2'd0))
		else $error("command popped from an empty queue");
`endif

endmodule

/* rtl/core/htfl_back.sv */
// ----------------------------------------------------------------------------
// htfl_back
// Executes one command at a time: reads the entry word, then updates the
// entry, the free-list head and the fresh counter, and loads the response.
// ----------------------------------------------------------------------------
module htfl_back #(
	parameter int MAX_HANDLES = htfl_pkg::MAX_HANDLES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  htfl_pkg::cmd_t                 cmd,
	input  logic [$clog2(MAX_HANDLES)-1:0] cmd_idx,
	input  logic                           cmd_valid,
	output logic                           cmd_ready,
	htfl_out_if.source                     rsp
);
	import htfl_pkg::*;

	localparam int HW      = $clog2(MAX_HANDLES);
	localparam int FRESH_W = HW + 1;
	localparam int WORD_W  = 1 + TYPE_W + HW;

	localparam logic [FRESH_W-1:0] FRESH_END   = FRESH_W'(MAX_HANDLES);
	localparam logic [FRESH_W-1:0] FRESH_FIRST = FRESH_W'(1);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic                st_q;
	cmd_t                cmd_q;
	logic [HW-1:0]       idx_q;
	logic [HW-1:0]       free_head_q;
	logic [FRESH_W-1:0]  next_fresh_q;

	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [HW-1:0]       out_handle_q;
	logic [TYPE_W-1:0]   out_type_q;

	logic                take;
	logic                exec_fire;
	logic [HW-1:0]       rd_addr;
	logic [WORD_W-1:0]   rd_word;
	logic                rd_live;
	logic [TYPE_W-1:0]   rd_type;
	logic [HW-1:0]       rd_link;
	logic                live;

	logic                wr_en;
	logic [HW-1:0]       wr_addr;
	logic [WORD_W-1:0]   wr_word;
	logic [HW-1:0]       nx_free_head;
	logic [FRESH_W-1:0]  nx_fresh;
	logic [STATUS_W-1:0] res_status;
	logic [HW-1:0]       res_handle;
	logic [TYPE_W-1:0]   res_type;

	assign cmd_ready = (st_q == S_IDLE);
	assign take      = cmd_valid && cmd_ready;
	assign exec_fire = (st_q == S_EXEC) && (!out_valid_q || rsp.ready);

	// add pops the free-list head; free and lookup read the addressed entry
	assign rd_addr = (cmd.op == OP_ADD) ? free_head_q : cmd_idx;

	htfl_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MAX_HANDLES)
	) u_entry_ram (
		.clk   (clk),
		.we    (exec_fire && wr_en),
		.waddr (wr_addr),
		.wdata (wr_word),
		.re    (take),
		.raddr (rd_addr),
		.rdata (rd_word)
	);

	assign {rd_live, rd_type, rd_link} = rd_word;

	// entries at or above the fresh mark have not been written since the last destroy
	assign live = rd_live && ({1'b0, idx_q} < next_fresh_q);

	always_comb begin
		wr_en        = 1'b0;
		wr_addr      = idx_q;
		wr_word      = '0;
		nx_free_head = free_head_q;
		nx_fresh     = next_fresh_q;
		res_status   = STS_OK;
		res_handle   = '0;
		res_type     = '0;
		case (cmd_q.op)
			OP_ADD: begin
				if (!cmd_q.type_ok) begin
					res_status = STS_BAD_TYPE;
				end else if (free_head_q != '0) begin
					wr_en        = 1'b1;
					wr_addr      = free_head_q;
					wr_word      = {1'b1, cmd_q.obj_type, rd_link};
					nx_free_head = rd_link;
					res_handle   = free_head_q;
					res_type     = cmd_q.obj_type;
				end else if (next_fresh_q < FRESH_END) begin
					wr_en      = 1'b1;
					wr_addr    = next_fresh_q[HW-1:0];
					wr_word    = {1'b1, cmd_q.obj_type, {HW{1'b0}}};
					nx_fresh   = next_fresh_q + FRESH_FIRST;
					res_handle = next_fresh_q[HW-1:0];
					res_type   = cmd_q.obj_type;
				end else begin
					res_status = STS_FULL;
				end
			end
			OP_FREE: begin
				if (!cmd_q.hid_ok || !live) begin
					res_status = STS_NOT_FOUND;
				end else begin
					wr_en        = 1'b1;
					wr_word      = {1'b0, rd_type, free_head_q};
					nx_free_head = idx_q;
					res_handle   = idx_q;
					res_type     = rd_type;
				end
			end
			OP_LOOKUP: begin
				if (!cmd_q.hid_ok || !live || rd_type == TYPE_RESERVED ||
					(cmd_q.want_type != TYPE_ANY && rd_type != cmd_q.want_type)) begin
					res_status = STS_NOT_FOUND;
				end else begin
					res_handle = idx_q;
					res_type   = rd_type;
				end
			end
			OP_DESTROY: begin
				nx_free_head = '0;
				nx_fresh     = FRESH_FIRST;
			end
			default: begin
				res_status = STS_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_q <= cmd;
			idx_q <= cmd_idx;
		end
		if (exec_fire) begin
			out_status_q <= res_status;
			out_handle_q <= res_handle;
			out_type_q   <= res_type;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= S_IDLE;
			free_head_q  <= '0;
			next_fresh_q <= FRESH_FIRST;
			out_valid_q  <= 1'b0;
		end else begin
			if (take) begin
				st_q <= S_EXEC;
			end else if (exec_fire) begin
				st_q <= S_IDLE;
			end
			if (exec_fire) begin
				free_head_q  <= nx_free_head;
				next_fresh_q <= nx_fresh;
				out_valid_q  <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_status_q;
	assign rsp.result_handle = out_handle_q;
	assign rsp.result_type   = out_type_q;

`ifndef SYNTHESIS
	a_fresh_range: assert property (@(posedge clk) disable iff (!arst_n)
		next_fresh_q != '0 && next_fresh_q <= FRESH_END)
		else $error("fresh counter out of range");
	a_head_below_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, free_head_q} < next_fresh_q)
		else $error("free-list head points at an unallocated entry");
	a_take_then_exec: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (st_q == S_EXEC) && !cmd_ready)
		else $error("command taken without entering execute");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q != STS_OK) |->
		(out_handle_q == '0 && out_type_q == '0))
		else $error("failed response carries a handle or type");
`endif

endmodule

/* rtl/core/handle_table_free_list.sv */
// Handle table with a LIFO free list. Each request word (add, free, lookup or
// destroy) gets exactly one response word, in order. An operation occupies the
// execute engine for a read of the entry RAM and then a write back of the
// entry along with the free-list head and fresh counter, and the engine takes
// no new word until that write back is done; a two-entry request queue and a
// response register let both sides stall independently. Destroy passes through
// the same steps: the table is emptied by resetting the fresh counter, with no
// clearing pass, and likewise no clearing pass runs after reset. Entry 0 is
// never handed out.
// ----------------------------------------------------------------------------
// handle_table_free_list
// Top level: request classification front end, queue, and entry execute engine.
// ----------------------------------------------------------------------------
module handle_table_free_list #(
	parameter int MAX_HANDLES = htfl_pkg::MAX_HANDLES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	htfl_in_if.sink    req,
	htfl_out_if.source rsp
);
	import htfl_pkg::*;

	localparam int HW = $clog2(MAX_HANDLES);

	cmd_t          cmd;
	logic [HW-1:0] cmd_idx;
	logic          cmd_valid;
	logic          cmd_ready;

	htfl_front #(
		.MAX_HANDLES (MAX_HANDLES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.cmd_idx   (cmd_idx),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready)
	);

	htfl_back #(
		.MAX_HANDLES (MAX_HANDLES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_idx   (cmd_idx),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.rsp       (rsp)
	);

endmodule
